### hdl/ppt_pkg.sv
// ppt_pkg: shared types and constants for the playback progress timer.
// Used by ppt_step and playback_progress_timer; depends on nothing else.
`default_nettype none

package ppt_pkg;

  // Event kinds carried in the input tuser field
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_SERIAL = 2'd1,
    OP_BTN1   = 2'd2,
    OP_BTN3   = 2'd3
  } ppt_op_t;

  // Send codes reported on a counted button release
  typedef enum logic [2:0] {
    CODE_NONE    = 3'd0,
    CODE_SHORT_1 = 3'd1,
    CODE_SHORT_3 = 3'd2,
    CODE_LONG_1  = 3'd3,
    CODE_LONG_3  = 3'd4
  } ppt_code_t;

  // Configuration register indexes
  localparam logic [1:0] REG_TICKS_PER_SECOND = 2'd0;
  localparam logic [1:0] REG_LONG_PRESS_TICKS = 2'd1;

  localparam logic [15:0] TPS_RESET = 16'd100;
  localparam logic [15:0] LPT_RESET = 16'd50;

  // Serial command buffer
  localparam int          CMD_LEN    = 4;
  localparam logic [2:0]  CMD_LEN_C  = 3'd4;
  localparam logic [2:0]  CMD_PAIR_C = 3'd2;
  localparam logic [7:0]  CH_ZERO    = 8'h30;
  localparam logic [7:0]  CH_P       = 8'h50;
  localparam logic [7:0]  CH_A       = 8'h41;
  localparam logic [7:0]  CH_L       = 8'h4c;
  localparam logic [7:0]  CH_NL      = 8'h0a;

  localparam logic [5:0]  LAST_SEC   = 6'd59;
  localparam logic [5:0]  LAST_MIN   = 6'd59;

  // Playback flags and per-button level
  typedef struct packed {
    logic       run;
    logic       pause;
    logic       play;
    logic       armed;
    logic [1:0] down;
  } ppt_ctl_t;

  // Counter and prescaler
  typedef struct packed {
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [15:0] tick;
  } ppt_cnt_t;

  // One result item
  typedef struct packed {
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic       update;
    ppt_code_t  code;
    logic       running;
  } ppt_result_t;

endpackage

`default_nettype wire

### hdl/ppt_step.sv
// ppt_step: next-state and result logic for one event of the progress timer.
// Purely combinational; imports ppt_pkg. State registers live in the top level.
`default_nettype none

module ppt_step
  import ppt_pkg::*;
#(
  parameter int HOLD_WIDTH = 16
) (
  input  ppt_op_t               op,
  input  logic [7:0]            data_byte,
  input  logic                  pressed,
  input  logic [15:0]           ticks_per_second,
  input  logic [15:0]           long_press_ticks,
  input  ppt_ctl_t              ctl,
  input  ppt_cnt_t              cnt,
  input  logic [12:0]           min_limit,
  input  logic [12:0]           sec_limit,
  input  logic [7:0]            rx_chars [CMD_LEN],
  input  logic [2:0]            rx_count,
  input  logic [HOLD_WIDTH-1:0] hold [2],
  output ppt_ctl_t              ctl_nxt,
  output ppt_cnt_t              cnt_nxt,
  output logic [12:0]           min_limit_nxt,
  output logic [12:0]           sec_limit_nxt,
  output logic [7:0]            rx_chars_nxt [CMD_LEN],
  output logic [2:0]            rx_count_nxt,
  output logic [HOLD_WIDTH-1:0] hold_nxt [2],
  output ppt_result_t           result
);

  localparam int CW = (HOLD_WIDTH > 16) ? HOLD_WIDTH : 16;

  // tens*10 + units of (byte - '0'), two's complement in 13 bits
  function automatic logic [12:0] digit_pair(input logic [7:0] tens, input logic [7:0] units);
    logic [12:0] td;
    logic [12:0] ud;
    td = {5'd0, tens} - {5'd0, CH_ZERO};
    ud = {5'd0, units} - {5'd0, CH_ZERO};
    return (td << 3) + (td << 1) + ud;
  endfunction

  logic btn;
  logic is_long;

  assign btn     = (op == OP_BTN3);
  assign is_long = CW'(hold[btn]) >= CW'(long_press_ticks);

  always_comb begin
    ctl_nxt       = ctl;
    cnt_nxt       = cnt;
    min_limit_nxt = min_limit;
    sec_limit_nxt = sec_limit;
    rx_chars_nxt  = rx_chars;
    rx_count_nxt  = rx_count;
    hold_nxt      = hold;
    result.update = 1'b0;
    result.code   = CODE_NONE;

    case (op)
      OP_TICK: begin
        cnt_nxt.tick = cnt.tick + 16'd1;
        for (int b = 0; b < 2; b++) begin
          if (ctl.down[b] && (hold[b] != {HOLD_WIDTH{1'b1}})) begin
            hold_nxt[b] = hold[b] + 1'b1;
          end
        end
        if (ctl.run && (cnt_nxt.tick >= ticks_per_second)) begin
          result.update = 1'b1;
          cnt_nxt.tick  = '0;
          if (cnt.second == LAST_SEC) begin
            cnt_nxt.second = '0;
            cnt_nxt.minute = (cnt.minute == LAST_MIN) ? 6'd0 : cnt.minute + 6'd1;
          end else begin
            cnt_nxt.second = cnt.second + 6'd1;
          end
          // limit reached: back to zero
          if (({7'd0, cnt_nxt.second} == sec_limit) &&
              ({7'd0, cnt_nxt.minute} == min_limit)) begin
            cnt_nxt.second = '0;
            cnt_nxt.minute = '0;
          end
        end
      end

      OP_SERIAL: begin
        // a zero byte is not stored, but the checks below still run
        if ((rx_count < CMD_LEN_C) && (data_byte != 8'd0)) begin
          rx_chars_nxt[rx_count[1:0]] = data_byte;
          rx_count_nxt                = rx_count + 3'd1;
        end
        if ((rx_count_nxt == CMD_PAIR_C) && (rx_chars_nxt[0] == CH_P) &&
            ((rx_chars_nxt[1] == CH_A) || (rx_chars_nxt[1] == CH_L))) begin
          if (rx_chars_nxt[1] == CH_A) begin
            if (ctl.play) begin
              ctl_nxt.run   = 1'b0;
              ctl_nxt.pause = 1'b1;
              ctl_nxt.play  = 1'b0;
            end
          end else if (ctl.pause) begin
            ctl_nxt.run   = 1'b1;
            ctl_nxt.pause = 1'b0;
            ctl_nxt.play  = 1'b1;
          end
          rx_count_nxt = '0;
          for (int i = 0; i < CMD_LEN; i++) rx_chars_nxt[i] = '0;
        end else if ((rx_count_nxt == CMD_LEN_C) || (data_byte == CH_NL)) begin
          if (rx_count_nxt == CMD_LEN_C) begin
            cnt_nxt       = '0;
            ctl_nxt.run   = 1'b1;
            ctl_nxt.play  = 1'b1;
            min_limit_nxt = digit_pair(rx_chars_nxt[0], rx_chars_nxt[1]);
            sec_limit_nxt = digit_pair(rx_chars_nxt[2], rx_chars_nxt[3]);
          end
          rx_count_nxt = '0;
          for (int i = 0; i < CMD_LEN; i++) rx_chars_nxt[i] = '0;
        end
      end

      default: begin
        if (!ctl.armed) begin
          // first button event only arms the buttons
          ctl_nxt.armed = 1'b1;
        end else if (pressed) begin
          ctl_nxt.down[btn] = 1'b1;
          hold_nxt[btn]     = '0;
        end else begin
          ctl_nxt.down[btn] = 1'b0;
          if (!is_long) begin
            cnt_nxt      = '0;
            ctl_nxt.run  = 1'b1;
            ctl_nxt.play = 1'b1;
            result.code  = btn ? CODE_SHORT_3 : CODE_SHORT_1;
          end else if (!btn) begin
            ctl_nxt.run   = 1'b1;
            ctl_nxt.pause = 1'b0;
            ctl_nxt.play  = 1'b1;
            result.code   = CODE_LONG_1;
          end else begin
            ctl_nxt.run   = 1'b0;
            ctl_nxt.pause = 1'b1;
            ctl_nxt.play  = 1'b0;
            result.code   = CODE_LONG_3;
          end
        end
      end
    endcase

    result.minutes = cnt_nxt.minute;
    result.seconds = cnt_nxt.second;
    result.running = ctl_nxt.run;
  end

endmodule

`default_nettype wire

### hdl/playback_progress_timer.sv
// playback_progress_timer: top level of the minutes:seconds progress timer.
// Holds the input register, state registers and result register; uses ppt_step, ppt_pkg.
//
//   channel  direction  handshake             payload
//   in_      slave      in_tvalid/in_tready   tuser: operation; tdata: data_byte, pressed
//   out_     master     out_tvalid/out_tready tdata: minutes, seconds, update, code, running
//   cfg_     slave      cfg_valid/cfg_ready   cfg_index, cfg_data
//
// One result per input transaction, passing through the input register and then the
// result register; throughput is one transaction per clock while out_ does not stall,
// as the event update between those two registers is combinational.
// Synchronous active-low rst_n clears valid flags and timer state, loads register defaults.
// A stalled out_ holds its result; in_ still takes one more transaction into
// the input register, then drops in_tready until the result leaves.
// cfg_ready is always high; writes are meant for idle periods only.
`default_nettype none

module playback_progress_timer
  import ppt_pkg::*;
#(
  parameter int HOLD_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input events
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [1:0]  in_tuser,   // [1:0] operation
  input  wire logic [15:0] in_tdata,   // [7:0] data_byte, [8] pressed, [15:9] zero
  // results
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [5:0] minutes_now, [11:6] seconds_now,
                                       // [12] display_update, [15:13] send_code,
                                       // [16] is_running, [23:17] zero
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  // input register
  logic        in_valid_r;
  ppt_op_t     in_op_r;
  logic [7:0]  in_byte_r;
  logic        in_pressed_r;

  // result register
  logic        out_valid_r;
  ppt_result_t out_res_r;

  // configuration
  logic [15:0] tps_r;
  logic [15:0] lpt_r;

  // block state
  ppt_ctl_t              ctl_r,       ctl_nxt;
  ppt_cnt_t              cnt_r,       cnt_nxt;
  logic [12:0]           min_lim_r,   min_lim_nxt;
  logic [12:0]           sec_lim_r,   sec_lim_nxt;
  logic [7:0]            rx_chars_r   [CMD_LEN];
  logic [7:0]            rx_chars_nxt [CMD_LEN];
  logic [2:0]            rx_count_r,  rx_count_nxt;
  logic [HOLD_WIDTH-1:0] hold_r       [2];
  logic [HOLD_WIDTH-1:0] hold_nxt     [2];
  ppt_result_t           res_nxt;

  logic fire;
  logic in_acc;

  // process the held event when the result register is free or draining
  assign fire      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || fire;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  ppt_step #(
    .HOLD_WIDTH (HOLD_WIDTH)
  ) u_step (
    .op               (in_op_r),
    .data_byte        (in_byte_r),
    .pressed          (in_pressed_r),
    .ticks_per_second (tps_r),
    .long_press_ticks (lpt_r),
    .ctl              (ctl_r),
    .cnt              (cnt_r),
    .min_limit        (min_lim_r),
    .sec_limit        (sec_lim_r),
    .rx_chars         (rx_chars_r),
    .rx_count         (rx_count_r),
    .hold             (hold_r),
    .ctl_nxt          (ctl_nxt),
    .cnt_nxt          (cnt_nxt),
    .min_limit_nxt    (min_lim_nxt),
    .sec_limit_nxt    (sec_lim_nxt),
    .rx_chars_nxt     (rx_chars_nxt),
    .rx_count_nxt     (rx_count_nxt),
    .hold_nxt         (hold_nxt),
    .result           (res_nxt)
  );

  // control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      tps_r       <= TPS_RESET;
      lpt_r       <= LPT_RESET;
      ctl_r       <= '0;
      cnt_r       <= '0;
      min_lim_r   <= '0;
      sec_lim_r   <= '0;
      rx_count_r  <= '0;
      for (int i = 0; i < CMD_LEN; i++) rx_chars_r[i] <= '0;
      hold_r[0]   <= '0;
      hold_r[1]   <= '0;
    end else begin
      if (in_acc) begin
        in_valid_r <= 1'b1;
      end else if (fire) begin
        in_valid_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_index)
          REG_TICKS_PER_SECOND: tps_r <= cfg_data;
          REG_LONG_PRESS_TICKS: lpt_r <= cfg_data;
          default: ;  // ignore writes past the register list
        endcase
      end
      // advance the timer state on each processed event
      if (fire) begin
        ctl_r      <= ctl_nxt;
        cnt_r      <= cnt_nxt;
        min_lim_r  <= min_lim_nxt;
        sec_lim_r  <= sec_lim_nxt;
        rx_count_r <= rx_count_nxt;
        rx_chars_r <= rx_chars_nxt;
        hold_r     <= hold_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_op_r      <= ppt_op_t'(in_tuser);
      in_byte_r    <= in_tdata[7:0];
      in_pressed_r <= in_tdata[8];
    end
    if (fire) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r.running, out_res_r.code, out_res_r.update,
                       out_res_r.seconds, out_res_r.minutes};

  // the input side stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_valid_r && !out_tready))
    else $error("input stalled without a held result");

  // counter stays inside 59:59
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_res_r.seconds <= LAST_SEC) && (out_res_r.minutes <= LAST_MIN)))
    else $error("progress counter out of range");

  // a display refresh only comes from a tick, never with a send code
  a_update_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.update) |-> (out_res_r.code == CODE_NONE))
    else $error("display update together with a send code");

  // send code agrees with the run flag it leaves behind
  a_code_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_res_r.code != CODE_NONE)) |->
      (out_res_r.running == (out_res_r.code != CODE_LONG_3)))
    else $error("send code inconsistent with run flag");

  // a processed event always leaves a result waiting
  a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("processed event produced no result");

endmodule

`default_nettype wire

### verif/tb_playback_progress_timer.sv
// tb_playback_progress_timer: self-checking testbench for the playback progress timer.
// Drives tick, serial and button events, predicts every result and checks it in order.
// Depends on ppt_pkg and playback_progress_timer from the hdl folder.
`default_nettype none

module tb_playback_progress_timer;
  timeunit 1ns;
  timeprecision 1ps;

  import ppt_pkg::*;

  localparam int HOLD_W          = 16;
  localparam int STALL_LIMIT     = 2000;  // cycles without any transaction
  localparam int HOLD_OFF_CYCLES = 300;   // long receiver stall
  localparam int DRAIN_CYCLES    = 4;     // input register plus result register, with margin

  // ---------------------------------------------------------------------------
  // Clock, reset and block ports; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser   = OP_TICK;   // [1:0] operation
  logic [15:0] in_tdata   = '0;        // [7:0] data_byte, [8] pressed, [15:9] zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;              // [5:0] minutes_now, [11:6] seconds_now,
                                       // [12] display_update, [15:13] send_code,
                                       // [16] is_running, [23:17] zero
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index  = REG_TICKS_PER_SECOND;
  logic [15:0] cfg_data   = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  playback_progress_timer #(
    .HOLD_WIDTH (HOLD_W)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Shared run state
  // ---------------------------------------------------------------------------
  ppt_result_t expected_results[$];  // one entry per accepted event, oldest first
  int          error_count    = 0;
  int          events_sent    = 0;
  int          send_idle_pct  = 26;
  int          recv_idle_pct  = 62;
  int          stalled_cycles = 0;
  bit          hold_off_req   = 1'b0;

  // ---------------------------------------------------------------------------
  // Timer predictor: own copy of configuration and state
  // ---------------------------------------------------------------------------
  logic [15:0]       tps = TPS_RESET;
  logic [15:0]       lpt = LPT_RESET;
  logic [7:0]        rx_buf [CMD_LEN];
  int                rx_len  = 0;
  int                min_lim = 0;
  int                sec_lim = 0;
  logic [5:0]        minute_cnt = '0;
  logic [5:0]        second_cnt = '0;
  logic [15:0]       tick_cnt   = '0;
  logic              running = 1'b0;
  logic              paused  = 1'b0;
  logic              playing = 1'b0;
  logic              armed   = 1'b0;
  logic              btn_down [2] = '{1'b0, 1'b0};
  logic [HOLD_W-1:0] hold_cnt [2] = '{'0, '0};

  initial foreach (rx_buf[i]) rx_buf[i] = '0;

  function automatic void restart_count();
    tick_cnt   = '0;
    minute_cnt = '0;
    second_cnt = '0;
    running    = 1'b1;
    playing    = 1'b1;
  endfunction

  function automatic void pause_count();
    running = 1'b0;
    paused  = 1'b1;
    playing = 1'b0;
  endfunction

  function automatic void resume_count();
    running = 1'b1;
    paused  = 1'b0;
    playing = 1'b1;
  endfunction

  function automatic void clear_rx();
    rx_len = 0;
    foreach (rx_buf[i]) rx_buf[i] = '0;
  endfunction

  // Limit digits are taken as tens*10+units of (char - '0'), no range check
  function automatic int digit_pair(logic [7:0] tens, logic [7:0] units);
    return (int'(tens) - int'(CH_ZERO)) * 10 + (int'(units) - int'(CH_ZERO));
  endfunction

  // Advance the predicted state by one event and return the result it causes
  function automatic ppt_result_t predict_step(ppt_op_t op, logic [7:0] data_val,
                                               logic level);
    ppt_result_t r;
    int          b;
    r.update = 1'b0;
    r.code   = CODE_NONE;
    case (op)
      OP_TICK: begin
        tick_cnt = tick_cnt + 16'd1;
        for (b = 0; b < 2; b++)
          if (btn_down[b] && hold_cnt[b] != {HOLD_W{1'b1}})
            hold_cnt[b] = hold_cnt[b] + 1'b1;
        // prescaler is compared only while running
        if (running && tick_cnt >= tps) begin
          r.update   = 1'b1;
          tick_cnt   = '0;
          second_cnt = second_cnt + 6'd1;
          if (second_cnt == 6'd60) begin
            second_cnt = '0;
            minute_cnt = minute_cnt + 6'd1;
            if (minute_cnt == 6'd60)
              minute_cnt = '0;
          end
          if (int'(second_cnt) == sec_lim && int'(minute_cnt) == min_lim) begin
            second_cnt = '0;
            minute_cnt = '0;
          end
        end
      end
      OP_SERIAL: begin
        // zero bytes are dropped but the command checks still run
        if (rx_len < CMD_LEN && data_val != 8'h00) begin
          rx_buf[rx_len] = data_val;
          rx_len++;
        end
        if (rx_len == 2 && rx_buf[0] == CH_P && (rx_buf[1] == CH_A || rx_buf[1] == CH_L)) begin
          if (rx_buf[1] == CH_A) begin
            if (playing)
              pause_count();
          end else if (paused) begin
            resume_count();
          end
          clear_rx();
        end else if (rx_len == CMD_LEN || data_val == CH_NL) begin
          if (rx_len == CMD_LEN) begin
            restart_count();
            min_lim = digit_pair(rx_buf[0], rx_buf[1]);
            sec_lim = digit_pair(rx_buf[2], rx_buf[3]);
          end
          clear_rx();
        end
      end
      default: begin
        b = (op == OP_BTN1) ? 0 : 1;
        if (!armed) begin
          armed = 1'b1;  // first button event only arms
        end else if (level) begin
          btn_down[b] = 1'b1;
          hold_cnt[b] = '0;
        end else begin
          btn_down[b] = 1'b0;
          if (hold_cnt[b] < lpt) begin
            restart_count();
            r.code = (b == 0) ? CODE_SHORT_1 : CODE_SHORT_3;
          end else if (b == 0) begin
            resume_count();
            r.code = CODE_LONG_1;
          end else begin
            pause_count();
            r.code = CODE_LONG_3;
          end
        end
      end
    endcase
    r.minutes = minute_cnt;
    r.seconds = second_cnt;
    r.running = running;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one event; hold tvalid high across back-to-back transactions
  task automatic send_event(ppt_op_t op, logic [7:0] data_val, logic level);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'b0, level, data_val};
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(predict_step(op, data_val, level));
    events_sent++;
  endtask

  task automatic send_tick();
    send_event(OP_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  task automatic send_char(logic [7:0] c);
    send_event(OP_SERIAL, c, 1'($urandom_range(1)));
  endtask

  task automatic send_button(ppt_op_t op, logic level);
    send_event(op, 8'($urandom_range(255)), level);
  endtask

  // Drop tvalid and wait until every predicted result has been checked
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // Write one register while the block is idle and mirror it in the predictor
  task automatic write_register(logic [1:0] idx, logic [15:0] value);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_TICKS_PER_SECOND)
      tps = value;
    else
      lpt = value;
  endtask

  // Mostly a small decimal digit, now and then any byte at all
  function automatic logic [7:0] limit_digit(int hi);
    if ($urandom_range(7) == 0)
      return 8'($urandom_range(255));
    return CH_ZERO + 8'($urandom_range(hi));
  endfunction

  task automatic send_limit(logic [7:0] m1, logic [7:0] m0, logic [7:0] s1, logic [7:0] s0);
    send_char(m1);
    send_char(m0);
    send_char(s1);
    send_char(s0);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Short walk through every event kind and the corner cases of the protocol
  task automatic test_directed();
    write_register(REG_TICKS_PER_SECOND, 16'd1);
    write_register(REG_LONG_PRESS_TICKS, 16'd2);
    send_button(OP_BTN1, 1'b1);          // first button event: arms only
    send_tick();                         // stopped: no second
    send_char(8'h00);                    // zero byte is not buffered
    send_char(CH_P); send_char(CH_A);    // pause while not playing
    send_limit(CH_ZERO, CH_ZERO, CH_ZERO, CH_ZERO + 8'd2);
    send_tick(); send_tick();            // reach 00:02 limit, fall back to 00:00
    send_char(CH_P); send_char(CH_A);    // pause
    send_tick();
    send_char(CH_P); send_char(CH_L);    // resume
    send_char(CH_P); send_char(CH_L);    // resume while not paused
    send_char(CH_ZERO + 8'd1); send_char(CH_NL);  // short line only clears
    send_button(OP_BTN3, 1'b1); send_button(OP_BTN3, 1'b0);  // short three
    send_button(OP_BTN1, 1'b1); send_tick(); send_tick();
    send_button(OP_BTN1, 1'b0);          // long one
    send_button(OP_BTN3, 1'b1); send_tick(); send_tick();
    send_button(OP_BTN3, 1'b0);          // long three
    send_button(OP_BTN1, 1'b0);          // release while already up
    send_limit(CH_ZERO, CH_ZERO + 8'd1, CH_ZERO + 8'd2, CH_NL);  // newline as fourth byte
    send_button(OP_BTN1, 1'b1); send_button(OP_BTN1, 1'b1);  // press while down
    send_button(OP_BTN1, 1'b0);
  endtask

  // Stall the result side for a long stretch while events keep coming,
  // then hold the sender until everything has drained
  task automatic test_backpressure();
    hold_off_req = 1'b1;
    repeat (40)
      send_event(ppt_op_t'($urandom_range(3)), 8'($urandom_range(255)),
                 1'($urandom_range(1)));
    wait_drained();
  endtask

  // Mostly well-formed commands and button sequences, with some noise
  task automatic random_traffic(int n);
    int target;
    int kind;
    target = events_sent + n;
    while (events_sent < target) begin
      kind = $urandom_range(99);
      if (kind < 30) begin
        repeat ($urandom_range(1, 8)) send_tick();
      end else if (kind < 40) begin
        send_char(CH_P);
        send_char($urandom_range(1) ? CH_A : CH_L);
      end else if (kind < 52) begin
        send_limit(limit_digit(0), limit_digit(1), limit_digit(1), limit_digit(9));
      end else if (kind < 58) begin
        repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(32, 126)));
        send_char(CH_NL);
      end else if (kind < 66) begin
        send_char(8'($urandom_range(255)));
        if ($urandom_range(3) == 0)
          send_char(8'h00);
      end else if (kind < 92) begin
        kind = $urandom_range(1) ? OP_BTN1 : OP_BTN3;
        send_button(ppt_op_t'(kind), 1'b1);
        if ($urandom_range(9) == 0)
          send_button(ppt_op_t'(kind), 1'b1);
        repeat ($urandom_range(0, 30)) send_tick();
        send_button(ppt_op_t'(kind), 1'b0);
        if ($urandom_range(9) == 0)
          send_button(ppt_op_t'(kind), 1'b0);
      end else begin
        send_event(ppt_op_t'($urandom_range(3)), 8'($urandom_range(255)),
                   1'($urandom_range(1)));
      end
    end
  endtask

  task automatic test_random_phase(int s_pct, int r_pct, int n);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    write_register(REG_TICKS_PER_SECOND, 16'($urandom_range(1, 6)));
    write_register(REG_LONG_PRESS_TICKS, 16'($urandom_range(1, 24)));
    random_traffic(n);
  endtask

  // Run past a minute boundary with an unreachable limit; zero ticks per second
  // turns every running tick into a second
  task automatic test_counter_wrap();
    write_register(REG_TICKS_PER_SECOND, 16'd0);
    send_limit(CH_ZERO + 8'd9, CH_ZERO + 8'd9, CH_ZERO + 8'd9, CH_ZERO + 8'd9);
    repeat (62) send_tick();
  endtask

  // Largest settings: no second elapses and a held button stays short;
  // then the prescaler counts on while paused and passes a smaller setting
  task automatic test_long_stretch();
    write_register(REG_TICKS_PER_SECOND, 16'hFFFF);
    write_register(REG_LONG_PRESS_TICKS, 16'hFFFF);
    send_limit(CH_ZERO + 8'd9, CH_ZERO + 8'd9, CH_ZERO + 8'd9, CH_ZERO + 8'd9);
    send_button(OP_BTN3, 1'b1);
    repeat (40) send_tick();
    send_button(OP_BTN3, 1'b0);          // hold far below the long press limit
    send_char(CH_P); send_char(CH_A);
    repeat (15) send_tick();             // prescaler advances while paused
    send_char(CH_P); send_char(CH_L);
    write_register(REG_TICKS_PER_SECOND, 16'd10);
    repeat (12) send_tick();             // prescaler already past the new setting
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random ready, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int held;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_tready <= 1'b0;
        for (held = 0; held < HOLD_OFF_CYCLES; held++)
          @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: compare each result transaction with the oldest prediction
  // ---------------------------------------------------------------------------
  function automatic void check_field(string field, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, actual %0d", field, exp_val, act_val);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    ppt_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with no event pending: %h", out_tdata);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        check_field("minutes_now",    exp_r.minutes, out_tdata[5:0]);
        check_field("seconds_now",    exp_r.seconds, out_tdata[11:6]);
        check_field("display_update", exp_r.update,  out_tdata[12]);
        check_field("send_code",      exp_r.code,    out_tdata[15:13]);
        check_field("is_running",     exp_r.running, out_tdata[16]);
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      stalled_cycles <= 0;
    else
      stalled_cycles <= stalled_cycles + 1;
    if (stalled_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_backpressure();
    test_random_phase(26, 62, 430);
    test_random_phase(62, 26, 430);
    test_random_phase(0, 0, 430);
    test_counter_wrap();
    test_long_stretch();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
